### sv/smi_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the small matrix inverse block.
// No dependencies.
package smi_pkg;

    // default entry format: signed Q16.16
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // entries per item, row major
    localparam int NUM_ENTRIES = 9;

    // matrix size codes carried in tuser
    localparam logic [1:0] DIM_ONE   = 2'd1;
    localparam logic [1:0] DIM_TWO   = 2'd2;
    localparam logic [1:0] DIM_THREE = 2'd3;

    // tuser bit positions on the result side
    localparam int USER_SINGULAR  = 0;
    localparam int USER_SATURATED = 1;

    // cofactor k (adjugate entry, row major) = a[p]*a[q] - a[s]*a[t]
    localparam logic [3:0] COF_IDX [0:8][0:3] = '{
        '{4'd4, 4'd8, 4'd7, 4'd5},
        '{4'd2, 4'd7, 4'd1, 4'd8},
        '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8},
        '{4'd0, 4'd8, 4'd2, 4'd6},
        '{4'd3, 4'd2, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd6, 4'd4},
        '{4'd6, 4'd1, 4'd0, 4'd7},
        '{4'd0, 4'd4, 4'd3, 4'd1}
    };

endpackage

### sv/small_matrix_inverse.sv
`timescale 1ns / 1ps
// Inverse of a 1x1, 2x2 or 3x3 signed fixed-point matrix by adjugate and division.
// Depends on smi_pkg.
//
// Each item carries a size in tuser and nine row-major entries in tdata; the result
// is the inverse in the same format, with singular and saturated flags in tuser.
// Determinant and cofactors are formed exactly, then every adjugate entry is divided
// by the determinant with rounding to nearest (ties away from zero) and clipped to
// the signed range. The block is a pipeline that takes one item every cycle while
// the result side is not stalled; its restoring divider resolves one quotient bit
// per stage for all nine entries at once. A stall on the result side holds every
// stage in place.
module small_matrix_inverse
    import smi_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int TDATA_W   = ((NUM_ENTRIES * DATA_WIDTH + 7) / 8) * 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // m_r0_c0, m_r0_c1, m_r0_c2, m_r1_c0, ... m_r2_c2, zero padding
    input  logic [TDATA_W-1:0] s_axis_tdata,
    // dim
    input  logic [1:0]         s_axis_tuser,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // inv_r0_c0, inv_r0_c1, inv_r0_c2, inv_r1_c0, ... inv_r2_c2, zero padding
    output logic [TDATA_W-1:0] m_axis_tdata,
    // singular, saturated
    output logic [1:0]         m_axis_tuser
);

    localparam int W    = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int PW   = 2 * W;
    localparam int CW   = 2 * W + 1;
    localparam int DETW = 3 * W + 3;
    localparam int XA   = 4 * W + 5;
    localparam int XB   = 2 * W + 2 * F + 3;
    localparam int XW   = (XA > XB) ? XA : XB;
    localparam int QW   = W + 1;
    localparam int NE   = NUM_ENTRIES;
    localparam int NFR  = 7;
    localparam int NST  = NFR + W + 2;

    logic en;
    logic [NST-1:0] vld_reg;
    logic ov_reg;

    // advance the whole pipeline unless a result is held
    assign en            = !ov_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], s_axis_tvalid};
            ov_reg  <= vld_reg[NST-1];
        end
    end

    // stage 0: capture entries
    logic signed [W-1:0] a0_reg [0:NE-1];
    logic [1:0] dim0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NE; k++)
                a0_reg[k] <= s_axis_tdata[k*W +: W];
            dim0_reg <= s_axis_tuser;
        end
    end

    // stage 1: minor products
    logic signed [PW-1:0] p1_reg [0:2*NE-1];
    logic signed [W-1:0]  a1_reg [0:NE-1];
    logic [1:0] dim1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NE; k++)
            begin
                p1_reg[2*k]   <= a0_reg[COF_IDX[k][0]] * a0_reg[COF_IDX[k][1]];
                p1_reg[2*k+1] <= a0_reg[COF_IDX[k][2]] * a0_reg[COF_IDX[k][3]];
                a1_reg[k]     <= a0_reg[k];
            end
            dim1_reg <= dim0_reg;
        end
    end

    // stage 2: cofactors, adjugate picked by size
    logic signed [CW-1:0] cof_c [0:NE-1];
    logic signed [CW-1:0] adj_c [0:NE-1];
    logic signed [CW-1:0] adj2_reg [0:NE-1];
    logic signed [CW-1:0] det2_reg;
    logic signed [W-1:0]  r2_reg [0:2];
    logic [1:0] dim2_reg;

    always_comb
    begin
        for (int k = 0; k < NE; k++)
        begin
            cof_c[k] = CW'(p1_reg[2*k]) - CW'(p1_reg[2*k+1]);
            adj_c[k] = '0;
        end
        unique case (dim1_reg)
            DIM_THREE:
            begin
                for (int k = 0; k < NE; k++)
                    adj_c[k] = cof_c[k];
            end
            DIM_TWO:
            begin
                adj_c[0] = CW'(a1_reg[4]);
                adj_c[1] = -CW'(a1_reg[1]);
                adj_c[3] = -CW'(a1_reg[3]);
                adj_c[4] = CW'(a1_reg[0]);
            end
            DIM_ONE:
            begin
                adj_c[0] = {{(CW-1){1'b0}}, 1'b1};
            end
            default:
            begin
                adj_c[0] = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NE; k++)
                adj2_reg[k] <= adj_c[k];
            for (int j = 0; j < 3; j++)
                r2_reg[j] <= a1_reg[j];
            det2_reg <= cof_c[8];
            dim2_reg <= dim1_reg;
        end
    end

    // stage 3: determinant partial products, cofactor split into high and low halves
    logic signed [CW-1:0] pl3_reg [0:2];
    logic signed [CW-1:0] ph3_reg [0:2];
    logic signed [CW-1:0] adj3_reg [0:NE-1];
    logic signed [CW-1:0] det2_3_reg;
    logic signed [W-1:0]  a00_3_reg;
    logic [1:0] dim3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                pl3_reg[j] <= r2_reg[j] * $signed({1'b0, adj2_reg[3*j][W-1:0]});
                ph3_reg[j] <= r2_reg[j] * $signed(adj2_reg[3*j][CW-1:W]);
            end
            for (int k = 0; k < NE; k++)
                adj3_reg[k] <= adj2_reg[k];
            det2_3_reg <= det2_reg;
            a00_3_reg  <= r2_reg[0];
            dim3_reg   <= dim2_reg;
        end
    end

    // stage 4: determinant by size
    logic signed [DETW-1:0] det3_c;
    logic signed [DETW-1:0] det_c;
    logic signed [DETW-1:0] det4_reg;
    logic signed [CW-1:0]   adj4_reg [0:NE-1];

    always_comb
    begin
        det3_c = '0;
        for (int j = 0; j < 3; j++)
            det3_c = det3_c + (DETW'(ph3_reg[j]) <<< W) + DETW'(pl3_reg[j]);
        unique case (dim3_reg)
            DIM_THREE: det_c = det3_c;
            DIM_TWO:   det_c = DETW'(det2_3_reg);
            DIM_ONE:   det_c = DETW'(a00_3_reg);
            default:   det_c = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det4_reg <= det_c;
            for (int k = 0; k < NE; k++)
                adj4_reg[k] <= adj3_reg[k];
        end
    end

    // stage 5: magnitudes and result signs
    logic [DETW-1:0] dmag5_reg;
    logic [CW-1:0]   amag5_reg [0:NE-1];
    logic [NE-1:0]   neg5_reg;
    logic            sng5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dmag5_reg <= det4_reg[DETW-1] ? DETW'(-det4_reg) : DETW'(det4_reg);
            for (int k = 0; k < NE; k++)
            begin
                amag5_reg[k] <= adj4_reg[k][CW-1] ? CW'(-adj4_reg[k]) : CW'(adj4_reg[k]);
                neg5_reg[k]  <= adj4_reg[k][CW-1] ^ det4_reg[DETW-1];
            end
            sng5_reg <= (det4_reg == '0);
        end
    end

    // stage 6: rounded dividend and doubled divisor
    logic [XW-1:0] n6_reg [0:NE-1];
    logic [XW-1:0] d6_reg;
    logic [NE-1:0] neg6_reg;
    logic          sng6_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NE; k++)
                n6_reg[k] <= (XW'(amag5_reg[k]) << (2 * F + 1)) + XW'(dmag5_reg);
            d6_reg   <= XW'(dmag5_reg) << 1;
            neg6_reg <= neg5_reg;
            sng6_reg <= sng5_reg;
        end
    end

    // divider: entry stage flags quotients that cannot fit, then one bit per stage
    logic [XW-1:0] rem_reg [0:W+1][0:NE-1];
    logic [QW-1:0] q_reg   [0:W+1][0:NE-1];
    logic [XW-1:0] dd_reg  [0:W+1];
    logic [NE-1:0] ovf_reg [0:W+1];
    logic [NE-1:0] neg_reg [0:W+1];
    logic          sng_reg [0:W+1];
    logic [XW-1:0] dsh_c   [0:W];
    logic [NE-1:0] ge_c    [0:W];

    // compare each partial remainder with the divisor aligned to that stage's bit
    always_comb
    begin
        for (int s = 0; s <= W; s++)
        begin
            dsh_c[s] = dd_reg[s] << (W - s);
            for (int k = 0; k < NE; k++)
                ge_c[s][k] = (rem_reg[s][k] >= dsh_c[s]);
        end
    end

    // load the entry stage, then subtract the shifted divisor where it fits and record the bit
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NE; k++)
            begin
                rem_reg[0][k] <= n6_reg[k];
                q_reg[0][k]   <= '0;
                ovf_reg[0][k] <= (n6_reg[k] >= (d6_reg << (W + 1)));
            end
            dd_reg[0]  <= d6_reg;
            neg_reg[0] <= neg6_reg;
            sng_reg[0] <= sng6_reg;
            for (int s = 0; s <= W; s++)
            begin
                for (int k = 0; k < NE; k++)
                begin
                    rem_reg[s+1][k] <= ge_c[s][k] ? rem_reg[s][k] - dsh_c[s] : rem_reg[s][k];
                    q_reg[s+1][k]   <= q_reg[s][k] | (QW'(ge_c[s][k]) << (W - s));
                end
                dd_reg[s+1]  <= dd_reg[s];
                ovf_reg[s+1] <= ovf_reg[s];
                neg_reg[s+1] <= neg_reg[s];
                sng_reg[s+1] <= sng_reg[s];
            end
        end
    end

    // output stage: clip, apply sign, clear on a singular matrix
    logic [W-1:0] res_c [0:NE-1];
    logic [NE-1:0] sat_c;
    logic [QW-1:0] lim_c;
    logic [QW-1:0] val_c;
    logic [W-1:0] od_reg [0:NE-1];
    logic [1:0]   ou_reg;

    always_comb
    begin
        for (int k = 0; k < NE; k++)
        begin
            lim_c = neg_reg[W+1][k] ? {2'b01, {(W-1){1'b0}}} : {2'b00, {(W-1){1'b1}}};
            sat_c[k] = ovf_reg[W+1][k] || (q_reg[W+1][k] > lim_c);
            val_c = sat_c[k] ? lim_c : q_reg[W+1][k];
            res_c[k] = neg_reg[W+1][k] ? -val_c[W-1:0] : val_c[W-1:0];
            if (sng_reg[W+1])
            begin
                res_c[k] = '0;
                sat_c[k] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NE; k++)
                od_reg[k] <= res_c[k];
            ou_reg[USER_SINGULAR]  <= sng_reg[W+1];
            ou_reg[USER_SATURATED] <= |sat_c;
        end
    end

    // pack the result item
    always_comb
    begin
        m_axis_tdata = '0;
        for (int k = 0; k < NE; k++)
            m_axis_tdata[k*W +: W] = od_reg[k];
    end

    assign m_axis_tuser = ou_reg;

endmodule
